// ===== sv/ffa_pkg.sv =====
`timescale 1ns / 1ps
package ffa_pkg;

	// sizes
	localparam int ADDR_W       = 32;
	localparam int FREE_SLOTS   = 16;
	localparam int HEADER_BYTES = 8;
	localparam int CNT_W        = $clog2(FREE_SLOTS + 1);
	localparam int CMD_W        = 2;
	localparam int ST_W         = 3;
	localparam int CFG_IDX_W    = 1;

	// reset value of both heap registers
	localparam logic [ADDR_W-1:0] HEAP_RESET = 32'h0010_0000;

	// commands
	localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE       = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PAGE_ALLOC = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_REUSED  = 3'd0;
	localparam logic [ST_W-1:0] ST_BUMPED  = 3'd1;
	localparam logic [ST_W-1:0] ST_NOMEM   = 3'd2;
	localparam logic [ST_W-1:0] ST_FREED   = 3'd3;
	localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'd1;

	// one free-list entry
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] size;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic search;    // load a fresh match flag
		logic match_en;  // the item is an allocate that can hit
		logic valid;     // cell lies below the fill count
		logic commit;    // removal takes effect this cycle
		logic push;      // write the pushed entry into this cell
	} cell_ctl_t;

endpackage

// ===== sv/ffa_in_if.sv =====
`timescale 1ns / 1ps
interface ffa_in_if;
	logic                             valid;
	logic                             ready;
	logic [ffa_pkg::CMD_W-1:0]        cmd;
	logic [ffa_pkg::ADDR_W-1:0]       request_size;
	logic [ffa_pkg::ADDR_W-1:0]       block_address;
	logic [ffa_pkg::ADDR_W-1:0]       block_size;

	modport source (output valid, cmd, request_size, block_address, block_size, input ready);
	modport sink (input valid, cmd, request_size, block_address, block_size, output ready);
endinterface

// ===== sv/ffa_out_if.sv =====
`timescale 1ns / 1ps
interface ffa_out_if;
	logic                             valid;
	logic                             ready;
	logic [ffa_pkg::ADDR_W-1:0]       result_address;
	logic [ffa_pkg::ADDR_W-1:0]       granted_size;
	logic [ffa_pkg::ST_W-1:0]         status;
	logic [ffa_pkg::ADDR_W-1:0]       used_bytes;

	modport source (output valid, result_address, granted_size, status, used_bytes,
		input ready);
	modport sink (input valid, result_address, granted_size, status, used_bytes,
		output ready);
endinterface

// ===== sv/ffa_cell.sv =====
`timescale 1ns / 1ps
module ffa_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffa_pkg::cell_ctl_t          ctl,
	input  logic [ffa_pkg::ADDR_W-1:0]  rounded,
	input  ffa_pkg::entry_t             push_entry,
	input  ffa_pkg::entry_t             nb_entry,
	input  logic                        found_in,
	output logic                        found_out,
	input  logic                        taken_in,
	output logic                        taken_out,
	output logic                        pick,
	output ffa_pkg::entry_t             entry
);

	ffa_pkg::entry_t entry_q;
	logic            hit_q;

	// match flag, held until the next search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.search) begin
			hit_q <= ctl.match_en & ctl.valid & (entry_q.size >= rounded);
		end
	end

	// newest hit wins: nothing above this cell has hit yet
	assign pick      = hit_q & ~found_in;
	assign found_out = found_in | hit_q;
	// this cell is at or above the removed entry
	assign taken_out = taken_in | pick;

	// entry storage: push, or close the gap by taking the upper neighbour
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= push_entry;
		end else if (ctl.commit && taken_out) begin
			entry_q <= nb_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ===== sv/first_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
// result path: stage 1 registers, stage 2 registers, then the output register
// a new item is accepted only while stages 1 and 2 are empty; the free-list cells compare in
//   the cycle after acceptance, the priority pick, entry shift and pointer update in stage 2
// a waiting result stalls the following item in stage 2, and the input with it
// reset (arst_n, asynchronous): heap_base = heap_limit = bump pointer = 0x100000,
//   free list empty; list entries themselves are not reset
module first_fit_free_list_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0]      cfg_data,
	ffa_in_if.sink                          req_ch,
	ffa_out_if.source                       rsp_ch
);

	localparam int AW = ffa_pkg::ADDR_W;
	localparam int NS = ffa_pkg::FREE_SLOTS;
	localparam int CW = ffa_pkg::CNT_W;

	// architectural state
	logic [AW-1:0] base_q, limit_q, bump_q;
	logic [CW-1:0] count_q;

	// stage 1 registers
	logic                        v_s1;
	logic [ffa_pkg::CMD_W-1:0]   cmd_s1;
	logic [AW-1:0]               req_s1, baddr_s1, bsize_s1, rounded_s1;
	logic                        rovf_s1;

	// stage 2 registers
	logic                        v_s2;
	logic [ffa_pkg::CMD_W-1:0]   cmd_s2;
	logic [AW-1:0]               req_s2, baddr_s2, bsize_s2, rounded_s2;
	logic                        rovf_s2;
	logic [AW-1:0]               alloc_at_s2, alloc_end_s2, aligned_s2, page_end_s2;
	logic                        alloc_fit_s2, align_ovf_s2, page_fit_s2;

	// output register
	logic                        out_v_q;
	logic [AW-1:0]               out_addr_q, out_gsz_q, out_used_q;
	logic [ffa_pkg::ST_W-1:0]    out_st_q;

	logic accept, done;
	logic [AW-1:0] rounded_in;

	assign req_ch.ready = ~v_s1 & ~v_s2;
	assign accept       = req_ch.valid & req_ch.ready;
	assign done         = v_s2 & (~out_v_q | rsp_ch.ready);

	// round the request up to a multiple of eight bytes
	assign rounded_in = (req_ch.request_size + AW'(7)) & ~AW'(7);

	// bump candidates, worked out while the cells compare
	logic [AW+1:0] alloc_end_w;
	logic [AW:0]   aligned_w, page_end_w;

	assign alloc_end_w = {2'b00, bump_q} + (AW+2)'(ffa_pkg::HEADER_BYTES)
		+ {2'b00, rounded_s1};
	assign aligned_w   = ({1'b0, bump_q} + (AW+1)'(12'hFFF)) & ~(AW+1)'(12'hFFF);
	assign page_end_w  = {1'b0, aligned_w[AW-1:0]} + {1'b0, req_s1};

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (done) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= req_ch.cmd;
			req_s1     <= req_ch.request_size;
			baddr_s1   <= req_ch.block_address;
			bsize_s1   <= req_ch.block_size;
			rounded_s1 <= rounded_in;
			rovf_s1    <= req_ch.request_size > 32'hFFFF_FFF8;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			cmd_s2       <= cmd_s1;
			req_s2       <= req_s1;
			baddr_s2     <= baddr_s1;
			bsize_s2     <= bsize_s1;
			rounded_s2   <= rounded_s1;
			rovf_s2      <= rovf_s1;
			alloc_at_s2  <= bump_q + AW'(ffa_pkg::HEADER_BYTES);
			alloc_end_s2 <= alloc_end_w[AW-1:0];
			alloc_fit_s2 <= alloc_end_w <= {2'b00, limit_q};
			aligned_s2   <= aligned_w[AW-1:0];
			align_ovf_s2 <= aligned_w[AW];
			page_end_s2  <= page_end_w[AW-1:0];
			page_fit_s2  <= page_end_w <= {1'b0, limit_q};
		end
	end

	// chain of free-list cells
	ffa_pkg::entry_t   ents  [0:NS];
	logic              found [0:NS];
	logic              taken [0:NS];
	logic [NS-1:0]     pick;
	ffa_pkg::cell_ctl_t ctl  [0:NS-1];
	ffa_pkg::entry_t   push_entry;
	logic              do_push, do_pop;

	assign ents[NS]   = '0;
	assign found[NS]  = 1'b0;
	assign taken[0]   = 1'b0;
	assign push_entry = '{addr: baddr_s2, size: bsize_s2};

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_cell
			always_comb begin
				ctl[k].search   = v_s1;
				ctl[k].match_en = (cmd_s1 == ffa_pkg::CMD_ALLOC) & ~rovf_s1;
				ctl[k].valid    = CW'(k) < count_q;
				ctl[k].commit   = done & do_pop;
				ctl[k].push     = done & do_push & (count_q == CW'(k));
			end

			ffa_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl[k]),
				.rounded    (rounded_s1),
				.push_entry (push_entry),
				.nb_entry   (ents[k+1]),
				.found_in   (found[k+1]),
				.found_out  (found[k]),
				.taken_in   (taken[k]),
				.taken_out  (taken[k+1]),
				.pick       (pick[k]),
				.entry      (ents[k])
			);
		end
	endgenerate

	// read out the picked entry
	ffa_pkg::entry_t pick_ent;
	always_comb begin
		pick_ent = '0;
		for (int i = 0; i < NS; i++) begin
			pick_ent = pick_ent | (pick[i] ? ents[i] : '0);
		end
	end

	// command decode and result
	logic [AW-1:0]            res_addr, res_gsz, next_bump;
	logic [ffa_pkg::ST_W-1:0] res_st;

	always_comb begin
		res_addr  = '0;
		res_gsz   = '0;
		res_st    = ffa_pkg::ST_IGNORED;
		next_bump = bump_q;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		case (cmd_s2)
			ffa_pkg::CMD_ALLOC: begin
				if (rovf_s2) begin
					res_st = ffa_pkg::ST_NOMEM;
				end else if (found[0]) begin
					res_st   = ffa_pkg::ST_REUSED;
					res_addr = pick_ent.addr;
					res_gsz  = pick_ent.size;
					do_pop   = 1'b1;
				end else if (alloc_fit_s2) begin
					res_st    = ffa_pkg::ST_BUMPED;
					res_addr  = alloc_at_s2;
					res_gsz   = rounded_s2;
					next_bump = alloc_end_s2;
				end else begin
					res_st = ffa_pkg::ST_NOMEM;
				end
			end
			ffa_pkg::CMD_FREE: begin
				if (baddr_s2 != '0 && count_q < CW'(NS)) begin
					res_st  = ffa_pkg::ST_FREED;
					do_push = 1'b1;
				end
			end
			ffa_pkg::CMD_PAGE_ALLOC: begin
				if (align_ovf_s2) begin
					res_st = ffa_pkg::ST_NOMEM;
				end else begin
					next_bump = aligned_s2;
					if (page_fit_s2) begin
						res_st    = ffa_pkg::ST_BUMPED;
						res_addr  = aligned_s2;
						res_gsz   = req_s2;
						next_bump = page_end_s2;
					end else begin
						res_st = ffa_pkg::ST_NOMEM;
					end
				end
			end
			default: begin
				res_st = ffa_pkg::ST_IGNORED;
			end
		endcase
	end

	// heap registers, bump pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= ffa_pkg::HEAP_RESET;
			limit_q <= ffa_pkg::HEAP_RESET;
			bump_q  <= ffa_pkg::HEAP_RESET;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ffa_pkg::REG_HEAP_BASE: begin
					base_q  <= cfg_data;
					bump_q  <= cfg_data;
					count_q <= '0;
				end
				ffa_pkg::REG_HEAP_LIMIT: begin
					limit_q <= cfg_data;
				end
				default: begin
					limit_q <= limit_q;
				end
			endcase
		end else if (done) begin
			bump_q <= next_bump;
			if (do_push) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && taken[NS]) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (done) begin
			out_v_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_addr_q <= res_addr;
			out_gsz_q  <= res_gsz;
			out_st_q   <= res_st;
			out_used_q <= next_bump - base_q;
		end
	end

	assign rsp_ch.valid          = out_v_q;
	assign rsp_ch.result_address = out_addr_q;
	assign rsp_ch.granted_size   = out_gsz_q;
	assign rsp_ch.status         = out_st_q;
	assign rsp_ch.used_bytes     = out_used_q;

endmodule

// ===== tb/ffa_checker.sv =====
`timescale 1ns / 1ps
module ffa_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0]    cfg_data,
	ffa_in_if                             req_ch,
	ffa_out_if                            rsp_ch,
	output int                            errors,
	output int                            pending,
	output int                            n_reused,
	output int                            n_bumped,
	output int                            n_nomem,
	output int                            n_freed,
	output int                            n_ignored,
	output int                            full_drops
);
	import ffa_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] size;
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] used;
	} heap_result_t;

	// shadow of the allocator state
	logic [ADDR_W-1:0] heap_base;
	logic [ADDR_W-1:0] heap_limit;
	logic [ADDR_W-1:0] bump;
	logic [ADDR_W-1:0] fl_addr [FREE_SLOTS];
	logic [ADDR_W-1:0] fl_size [FREE_SLOTS];
	int                fl_count;

	heap_result_t predicted_rsp [$];
	heap_result_t want;

	// one item through the shadow heap, returning the response it should give
	function automatic heap_result_t model_heap_step(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] req, input logic [ADDR_W-1:0] baddr,
			input logic [ADDR_W-1:0] bsize);
		heap_result_t      r;
		logic [ADDR_W-1:0] rounded;
		logic [ADDR_W+1:0] new_end;
		logic [ADDR_W:0]   aligned;
		int                hit;
		r.address = '0;
		r.size    = '0;
		r.status  = ST_IGNORED;
		hit       = -1;
		case (cmd)
			CMD_ALLOC: begin
				if (req > 32'hFFFF_FFF8) begin
					r.status = ST_NOMEM;
				end else begin
					rounded = (req + 32'd7) & ~32'd7;
					// newest entry first
					for (int i = fl_count - 1; i >= 0; i--)
						if (hit < 0 && fl_size[i] >= rounded)
							hit = i;
					if (hit >= 0) begin
						r.address = fl_addr[hit];
						r.size    = fl_size[hit];
						r.status  = ST_REUSED;
						for (int k = hit; k < fl_count - 1; k++) begin
							fl_addr[k] = fl_addr[k + 1];
							fl_size[k] = fl_size[k + 1];
						end
						fl_count--;
					end else begin
						new_end = {2'b00, bump} + 34'(HEADER_BYTES) + {2'b00, rounded};
						if (new_end > {2'b00, heap_limit}) begin
							r.status = ST_NOMEM;
						end else begin
							r.address = bump + 32'(HEADER_BYTES);
							r.size    = rounded;
							r.status  = ST_BUMPED;
							bump      = new_end[ADDR_W-1:0];
						end
					end
				end
			end
			CMD_FREE: begin
				if (baddr == '0 || fl_count >= FREE_SLOTS) begin
					if (baddr != '0)
						full_drops++;
				end else begin
					fl_addr[fl_count] = baddr;
					fl_size[fl_count] = bsize;
					fl_count++;
					r.status = ST_FREED;
				end
			end
			CMD_PAGE_ALLOC: begin
				aligned = ({1'b0, bump} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;
				if (aligned[ADDR_W]) begin
					r.status = ST_NOMEM;
				end else begin
					// alignment sticks even if the bump fails
					bump    = aligned[ADDR_W-1:0];
					new_end = {2'b00, bump} + {2'b00, req};
					if (new_end > {2'b00, heap_limit}) begin
						r.status = ST_NOMEM;
					end else begin
						r.address = bump;
						r.size    = req;
						r.status  = ST_BUMPED;
						bump      = new_end[ADDR_W-1:0];
					end
				end
			end
			default: ;
		endcase
		r.used = bump - heap_base;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [ADDR_W-1:0] exp_val,
			input logic [ADDR_W-1:0] got_val);
		if (got_val !== exp_val) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, field, exp_val,
				got_val);
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base  = HEAP_RESET;
			heap_limit = HEAP_RESET;
			bump       = HEAP_RESET;
			fl_count   = 0;
			predicted_rsp.delete();
			errors     = 0;
			n_reused   = 0;
			n_bumped   = 0;
			n_nomem    = 0;
			n_freed    = 0;
			n_ignored  = 0;
			full_drops = 0;
		end else begin
			// results come back in order
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (predicted_rsp.size() == 0) begin
					errors++;
					$display("%0t ns: result with none expected, address %h status %h",
						$time, rsp_ch.result_address, rsp_ch.status);
				end else begin
					want = predicted_rsp.pop_front();
					check_field("result_address", want.address, rsp_ch.result_address);
					check_field("granted_size", want.size, rsp_ch.granted_size);
					check_field("status", {29'd0, want.status}, {29'd0, rsp_ch.status});
					check_field("used_bytes", want.used, rsp_ch.used_bytes);
					case (want.status)
						ST_REUSED: n_reused++;
						ST_BUMPED: n_bumped++;
						ST_NOMEM:  n_nomem++;
						ST_FREED:  n_freed++;
						default:   n_ignored++;
					endcase
				end
			end
			if (req_ch.valid && req_ch.ready)
				predicted_rsp.push_back(model_heap_step(req_ch.cmd, req_ch.request_size,
					req_ch.block_address, req_ch.block_size));
			// a base write restarts the heap
			if (cfg_we) begin
				if (cfg_index == REG_HEAP_BASE) begin
					heap_base = cfg_data;
					bump      = cfg_data;
					fl_count  = 0;
				end else begin
					heap_limit = cfg_data;
				end
			end
		end
		pending = predicted_rsp.size();
	end

endmodule

// ===== tb/tb_first_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
module tb_first_fit_free_list_allocator;
	import ffa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYCLES = 80;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	ffa_in_if  req_ch ();
	ffa_out_if rsp_ch ();

	int errors, pending, full_drops;
	int n_reused, n_bumped, n_nomem, n_freed, n_ignored;
	bit idling = 1'b1;
	int hold_left = 0;
	int items_sent = 0;
	int settings_used = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	first_fit_free_list_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_ch    (req_ch),
		.rsp_ch    (rsp_ch)
	);

	ffa_checker heap_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_ch     (req_ch),
		.rsp_ch     (rsp_ch),
		.errors     (errors),
		.pending    (pending),
		.n_reused   (n_reused),
		.n_bumped   (n_bumped),
		.n_nomem    (n_nomem),
		.n_freed    (n_freed),
		.n_ignored  (n_ignored),
		.full_drops (full_drops)
	);

	// mostly small sizes so that freed blocks get reused, a few huge ones
	function automatic logic [ADDR_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 200);
		if (r < 85)
			return $urandom_range(0, 8192);
		if (r < 95)
			return $urandom;
		return 32'hFFFF_FFF0 + $urandom_range(0, 15);
	endfunction

	// offer one item, with an occasional gap before it
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] req_size,
			input logic [ADDR_W-1:0] baddr, input logic [ADDR_W-1:0] bsize);
		int gap;
		gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= cmd;
		req_ch.request_size  <= req_size;
		req_ch.block_address <= baddr;
		req_ch.block_size    <= bsize;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send_random(input int free_pct, output bit counted);
		logic [CMD_W-1:0]  c;
		logic [ADDR_W-1:0] rs, ba, bs;
		int                r;
		r  = $urandom_range(0, 99);
		rs = pick_size();
		ba = $urandom;
		bs = pick_size();
		if (r < free_pct) begin
			c = CMD_FREE;
			if ($urandom_range(0, 19) == 0)
				ba = '0;
		end else if (r < free_pct + 15) begin
			c = CMD_PAGE_ALLOC;
		end else if (r < free_pct + 18) begin
			c = CMD_UNKNOWN;
		end else begin
			c = CMD_ALLOC;
		end
		counted = !(c == CMD_UNKNOWN || (c == CMD_FREE && ba == '0));
		send_item(c, rs, ba, bs);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid and wait for every outstanding result
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (idling && (stall_left > 0 || $urandom_range(0, 5) == 0)) begin
				if (stall_left == 0)
					stall_left = $urandom_range(1, 10);
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [ADDR_W-1:0] base, limit;
		bit                set_base, counted;
		int                free_pct, n;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_HEAP_BASE;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.cmd           = CMD_ALLOC;
		req_ch.request_size  = '0;
		req_ch.block_address = '0;
		req_ch.block_size    = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset heap is empty: only a zero-size page request fits
		send_item(CMD_ALLOC, '0, '0, '0);
		send_item(CMD_PAGE_ALLOC, '0, '0, '0);
		send_item(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_idle();

		// small heap: rounding overflow, bump limit, reuse newest first, page alignment
		write_reg(REG_HEAP_BASE, 32'h0000_1000);
		write_reg(REG_HEAP_LIMIT, 32'h0002_0000);
		settings_used++;
		send_item(CMD_ALLOC, 32'd1, '0, '0);
		send_item(CMD_ALLOC, 32'hFFFF_FFF9, '0, '0);
		send_item(CMD_ALLOC, 32'hFFFF_FFF8, '0, '0);
		send_item(CMD_FREE, '0, '0, 32'd5);
		send_item(CMD_FREE, '0, 32'h0000_2000, 32'd64);
		send_item(CMD_FREE, '0, 32'h0000_3000, 32'd16);
		send_item(CMD_ALLOC, 32'd10, '0, '0);
		send_item(CMD_ALLOC, 32'd33, '0, '0);
		send_item(CMD_ALLOC, 32'd8, '0, '0);
		send_item(CMD_PAGE_ALLOC, 32'd100, '0, '0);
		send_item(CMD_PAGE_ALLOC, 32'h0002_0000, '0, '0);
		send_item(CMD_FREE, '0, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
		send_item(CMD_ALLOC, 32'hFFFF_FFF8, '0, '0);
		wait_idle();

		// heap at the top of the address space: alignment would wrap
		write_reg(REG_HEAP_BASE, 32'hFFFF_F001);
		write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
		settings_used++;
		send_item(CMD_PAGE_ALLOC, 32'd1, '0, '0);
		send_item(CMD_ALLOC, 32'd8, '0, '0);
		wait_idle();

		// random phases over a spread of heap settings
		for (int p = 0; p < PHASES; p++) begin
			set_base = 1'b1;
			case (p)
				0: begin base = 32'h0000_0000; limit = 32'hFFFF_FFFF; free_pct = 30; end
				1: begin set_base = 1'b0; limit = 32'h0000_4000; free_pct = 45; end
				2: begin base = 32'h0001_0000; limit = 32'h0002_0000; free_pct = 65; end
				3: begin base = 32'h8000_0123; limit = 32'h8000_8000; free_pct = 25; end
				4: begin base = 32'h0010_0000; limit = 32'h0008_0000; free_pct = 40; end
				5: begin base = 32'hFFFF_F800; limit = 32'hFFFF_FFFF; free_pct = 35; end
				6: begin base = 32'hFFFF_FFFF; limit = 32'hFFFF_FFFF; free_pct = 40; end
				default: begin base = 32'h4000_0000; limit = 32'h4010_0000; free_pct = 35; end
			endcase
			if (p == PHASES - 1)
				idling = 1'b0;
			if (set_base)
				write_reg(REG_HEAP_BASE, base);
			write_reg(REG_HEAP_LIMIT, limit);
			settings_used++;
			// long result hold-off so the block backs up into the input
			if (p == 2)
				hold_left = HOLD_CYCLES;
			n = 0;
			while (n < PHASE_ITEMS) begin
				send_random(free_pct, counted);
				if (counted)
					n++;
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("%0d items over %0d heap settings: %0d reused, %0d bumped, %0d out of memory",
			items_sent, settings_used, n_reused, n_bumped, n_nomem);
		$display("%0d frees stored, %0d dropped or ignored (%0d on a full free list)",
			n_freed, n_ignored, full_drops);
		if (errors == 0 && pending == 0) begin
			$display("first_fit_free_list_allocator regression: pass");
		end else begin
			$display("first_fit_free_list_allocator regression: fail");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#400000;
		$display("timeout with %0d results outstanding", pending);
		$display("first_fit_free_list_allocator regression: fail");
		$finish;
	end

endmodule
